// ----- rtl/tpi_frame_transceiver_defines.svh -----
// ----------------------------------------------------------------------------
// TPI frame transceiver assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TPI_FRAME_TRANSCEIVER_DEFINES_SVH
`define TPI_FRAME_TRANSCEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpi_frame_transceiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define TPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpi_frame_transceiver: next-cycle check failed");

`endif

// ----- rtl/tpi_ft_pkg.sv -----
// ----------------------------------------------------------------------------
// TPI frame transceiver package
// Types, codes and constants shared by the transceiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpi_ft_pkg;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RECV = 2'd1,
    KIND_IDLE = 2'd2,
    KIND_SLOT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2,
    OP_IDLE = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_PARITY   = 2'd2;

  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_DATA_LAST = 4'd8;
  localparam logic [3:0] PH_PARITY    = 4'd9;
  localparam logic [3:0] PH_STOP1     = 4'd10;
  localparam logic [3:0] PH_STOP2     = 4'd11;
  localparam logic [3:0] PH_BREAK     = 4'd12;
  localparam logic [3:0] PH_BREAK_END = 4'd13;

  localparam logic [1:0] CFG_START_WAIT = 2'd0;
  localparam logic [1:0] CFG_BREAK_LEN  = 2'd1;

  localparam logic [7:0] START_WAIT_RST = 8'd192;
  localparam logic [7:0] BREAK_LEN_RST  = 8'd26;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic [7:0] idle_count;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       drive_bit;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    op_t  op;
    logic busy;
  } eng_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tpi_ft_in_stage.sv -----
// ----------------------------------------------------------------------------
// TPI frame transceiver input stage
// Registers one incoming item and hands it to the frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpi_ft_in_stage
  import tpi_ft_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire in_item_t in_item,
  input  wire logic     take,
  output logic          item_vld,
  output in_item_t      item
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;
  logic     load;

  // The register refills in the same cycle that the engine drains it.
  assign in_tready = !vld_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

// ----- rtl/tpi_ft_engine.sv -----
// ----------------------------------------------------------------------------
// TPI frame transceiver engine
// Frame state and the per-slot update for send, receive and idle commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpi_ft_engine
  import tpi_ft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_vld,
  input  wire in_item_t   item,
  input  wire logic       out_free,
  input  wire logic [7:0] start_wait_limit,
  input  wire logic [7:0] break_length,
  output logic            take,
  output logic            res_vld,
  output out_item_t       res,
  output eng_stat_t       stat
);

  op_t        op_r,     op_nxt;
  logic [3:0] phase_r,  phase_nxt;
  logic [7:0] cnt_r,    cnt_nxt;
  logic [7:0] sr_r,     sr_nxt;
  logic       par_r,    par_nxt;
  logic [1:0] pend_r,   pend_nxt;

  logic is_slot;

  assign is_slot = (item.kind == KIND_SLOT);
  // A command never produces a result, so it does not wait for the output.
  assign take    = item_vld && (!is_slot || out_free);
  assign res_vld = take && is_slot;

  always_comb begin
    op_nxt    = op_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sr_nxt    = sr_r;
    par_nxt   = par_r;
    pend_nxt  = pend_r;
    res       = '{drive_bit: 1'b1, done_res: 1'b0, rx_byte: 8'd0, status: ST_OK};

    if (!is_slot) begin
      // Commands are dropped unless the engine is idle.
      if (op_r == OP_NONE) begin
        phase_nxt = PH_START;
        pend_nxt  = ST_OK;
        par_nxt   = 1'b0;
        unique case (item.kind)
          KIND_SEND: begin
            op_nxt  = OP_SEND;
            sr_nxt  = item.tx_byte;
            par_nxt = ^item.tx_byte;
          end
          KIND_RECV: begin
            op_nxt  = OP_RECV;
            sr_nxt  = 8'd0;
            cnt_nxt = start_wait_limit;
          end
          default: begin
            op_nxt  = OP_IDLE;
            cnt_nxt = item.idle_count;
          end
        endcase
      end
    end else begin
      unique case (op_r)
        OP_SEND: begin
          if (phase_r == PH_START) begin
            res.drive_bit = 1'b0;
          end else if (phase_r <= PH_DATA_LAST) begin
            res.drive_bit = sr_r[0];
            sr_nxt        = {1'b0, sr_r[7:1]};
          end else if (phase_r == PH_PARITY) begin
            res.drive_bit = par_r;
          end
          if (phase_r >= PH_STOP2) begin
            res.done_res = 1'b1;
            op_nxt       = OP_NONE;
            phase_nxt    = PH_START;
          end else begin
            phase_nxt = phase_r + 4'd1;
          end
        end
        OP_RECV: begin
          if (phase_r == PH_START) begin
            // Hunt for the start bit; a counter of one means the wait is spent.
            if (!item.line_in) begin
              phase_nxt = 4'd1;
            end else if (cnt_r == 8'd1) begin
              sr_nxt    = 8'd0;
              pend_nxt  = ST_NO_START;
              phase_nxt = PH_BREAK;
              cnt_nxt   = break_length;
            end else begin
              cnt_nxt = cnt_r - 8'd1;
            end
          end else if (phase_r <= PH_DATA_LAST) begin
            sr_nxt    = {item.line_in, sr_r[7:1]};
            par_nxt   = par_r ^ item.line_in;
            phase_nxt = phase_r + 4'd1;
          end else if (phase_r == PH_PARITY) begin
            if (item.line_in != par_r) begin
              pend_nxt  = ST_PARITY;
              phase_nxt = PH_BREAK;
              cnt_nxt   = break_length;
            end else begin
              phase_nxt = PH_STOP1;
            end
          end else if (phase_r == PH_STOP1) begin
            phase_nxt = PH_STOP2;
          end else if (phase_r == PH_BREAK) begin
            res.drive_bit = 1'b0;
            if (cnt_r == 8'd1) begin
              phase_nxt = PH_BREAK_END;
            end else begin
              cnt_nxt = cnt_r - 8'd1;
            end
          end else begin
            res.done_res = 1'b1;
            res.rx_byte  = sr_r;
            res.status   = (phase_r == PH_BREAK_END) ? pend_r : ST_OK;
            op_nxt       = OP_NONE;
            phase_nxt    = PH_START;
          end
        end
        OP_IDLE: begin
          if (cnt_r == 8'd1) begin
            res.done_res = 1'b1;
            op_nxt       = OP_NONE;
          end else begin
            cnt_nxt = cnt_r - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_NONE;
      phase_r <= PH_START;
      cnt_r   <= 8'd0;
      sr_r    <= 8'd0;
      par_r   <= 1'b0;
      pend_r  <= ST_OK;
    end else if (take) begin
      op_r    <= op_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sr_r    <= sr_nxt;
      par_r   <= par_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign stat.op   = op_r;
  assign stat.busy = (op_r != OP_NONE);

endmodule

`default_nettype wire

// ----- rtl/tpi_ft_out_stage.sv -----
// ----------------------------------------------------------------------------
// TPI frame transceiver output stage
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpi_ft_out_stage
  import tpi_ft_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_vld,
  input  wire out_item_t res,
  output logic           out_free,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output out_item_t      out_item
);

  logic      vld_r;
  logic      vld_nxt;
  out_item_t item_r;

  assign out_free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      item_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_item   = item_r;

endmodule

`default_nettype wire

// ----- rtl/tpi_frame_transceiver.sv -----
// ----------------------------------------------------------------------------
// TPI frame transceiver
// Bit-slot engine for the half-duplex TPI frame: send, receive, idle ones.
// ----------------------------------------------------------------------------
//  Channel | Direction | Carries
//  in_     | input     | commands and bit slots (kind, tx byte, idle count, line)
//  out_    | output    | one result per bit slot (drive, done, rx byte, status)
//  cfg_    | input     | start wait limit and break length writes
//
//  An accepted item waits in the input register while the engine works on it;
//  its result is registered into the output register when the engine takes the
//  item, and is offered downstream from there. One item per cycle while the output is not stalled.
//  Commands leave no result and are consumed even while the output is full.
//  A bit slot waits in the input register while the output register is stalled.
//  Synchronous active-low reset returns to idle with default register values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tpi_frame_transceiver_defines.svh"

module tpi_frame_transceiver
  import tpi_ft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // tx_byte[7:0], idle_count[15:8], line_in[16]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // drive_bit[0], rx_byte[8:1], status[10:9]
  output logic             out_tlast,  // done_res
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0] start_wait_r;
  logic [7:0] break_len_r;

  in_item_t  in_item;
  in_item_t  item;
  logic      item_vld;
  logic      take;
  logic      res_vld;
  out_item_t res;
  out_item_t out_item;
  logic      out_free;
  eng_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_wait_r <= START_WAIT_RST;
      break_len_r  <= BREAK_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START_WAIT) begin
        start_wait_r <= cfg_wdata;
      end else if (cfg_index == CFG_BREAK_LEN) begin
        break_len_r <= cfg_wdata;
      end
    end
  end

  assign in_item.kind       = kind_t'(in_tuser);
  assign in_item.tx_byte    = in_tdata[7:0];
  assign in_item.idle_count = in_tdata[15:8];
  assign in_item.line_in    = in_tdata[16];

  tpi_ft_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  tpi_ft_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_vld         (item_vld),
    .item             (item),
    .out_free         (out_free),
    .start_wait_limit (start_wait_r),
    .break_length     (break_len_r),
    .take             (take),
    .res_vld          (res_vld),
    .res              (res),
    .stat             (stat)
  );

  tpi_ft_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = {5'd0, out_item.status, out_item.rx_byte, out_item.drive_bit};
  assign out_tlast = out_item.done_res;

  // Only bit slots may produce a result, and never into a full output register.
  `TPI_ASSERT_NOW(a_res_from_slot, clk, rst_n, res_vld, item.kind == KIND_SLOT && out_free)
  // Status and received byte are only reported with the completing slot.
  `TPI_ASSERT_NOW(a_status_with_done, clk, rst_n, out_tvalid && !out_tlast,
                  out_tdata[10:9] == ST_OK && out_tdata[8:1] == 8'd0)
  // A completing slot always leaves the engine idle.
  `TPI_ASSERT_NEXT(a_done_to_idle, clk, rst_n, res_vld && res.done_res, !stat.busy)
  // A zero drive only comes from an active send or receive.
  `TPI_ASSERT_NOW(a_zero_drive_owner, clk, rst_n, res_vld && !res.drive_bit,
                  stat.op == OP_SEND || stat.op == OP_RECV)

endmodule

`default_nettype wire
